// File: src/ppmfwg_pkg.sv
// ----------------------------------------------------------------------------
// PPM frame waveform generator package
// Shared widths, codes, constant tables and the frame interface structs.
// ----------------------------------------------------------------------------
package ppmfwg_pkg;

   localparam int SAMPLE_W  = 12;
   localparam int SYMBOL_W  = 2;
   localparam int PAYLOAD_W = 32;
   localparam int INDEX_W   = 5;
   localparam int SUM_W     = 8;

   localparam logic [INDEX_W-1:0]  LAST_SAMPLE = 5'd31;
   localparam logic [INDEX_W-1:0]  LAST_SYMBOL = 5'd31;
   localparam logic [SAMPLE_W-1:0] OFFSET_RESET = 12'h800;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX   = 12'hFFF;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_LOAD   = 1'b1;

   // Header and length symbols together sum to 13.
   localparam logic [SUM_W-1:0] FIXED_SUM = 8'd13;

   typedef struct packed {
      logic sample_go;
      logic frame_end;
      logic load;
   } frame_ctrl_type;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic                data_frame;
   } frame_stat_type;

   function automatic logic [SAMPLE_W-1:0] pulse_shape(input logic [2:0] idx);
      logic [SAMPLE_W-1:0] val;
      case (idx)
         3'd0: val = 12'h148;
         3'd1: val = 12'h355;
         3'd2: val = 12'h5C1;
         3'd3: val = 12'h7FF;
         3'd4: val = 12'h7FF;
         3'd5: val = 12'h5C1;
         3'd6: val = 12'h355;
         3'd7: val = 12'h148;
         default: val = 12'h000;
      endcase
      return val;
   endfunction

   function automatic logic [SYMBOL_W-1:0] header_symbol(input logic [2:0] idx);
      logic [SYMBOL_W-1:0] sym;
      case (idx)
         3'd0: sym = 2'd3;
         3'd1: sym = 2'd0;
         3'd2: sym = 2'd3;
         3'd3: sym = 2'd0;
         3'd4: sym = 2'd3;
         3'd5: sym = 2'd2;
         3'd6: sym = 2'd0;
         3'd7: sym = 2'd1;
         default: sym = 2'd0;
      endcase
      return sym;
   endfunction

endpackage

// File: src/ppmfwg_shaper.sv
// ----------------------------------------------------------------------------
// PPM sample shaper
// Adds the pulse shape to the offset inside the symbol's slot and saturates.
// ----------------------------------------------------------------------------
module ppmfwg_shaper (
   input  logic [ppmfwg_pkg::SAMPLE_W-1:0] dc_offset,
   input  logic [ppmfwg_pkg::SYMBOL_W-1:0] symbol,
   input  logic [ppmfwg_pkg::INDEX_W-1:0]  sample_idx,
   output logic [ppmfwg_pkg::SAMPLE_W-1:0] sample
);

   logic [ppmfwg_pkg::SAMPLE_W-1:0] pulse;
   logic [ppmfwg_pkg::SAMPLE_W:0]   total;

   always_comb begin
      if (sample_idx[4:3] == symbol) begin
         pulse = ppmfwg_pkg::pulse_shape(sample_idx[2:0]);
      end else begin
         pulse = '0;
      end
      total = {1'b0, dc_offset} + {1'b0, pulse};
      if (total[ppmfwg_pkg::SAMPLE_W]) begin
         sample = ppmfwg_pkg::SAMPLE_MAX;
      end else begin
         sample = total[ppmfwg_pkg::SAMPLE_W-1:0];
      end
   end

endmodule

// File: src/ppmfwg_frame.sv
// ----------------------------------------------------------------------------
// PPM frame store
// Holds the current frame and the pending payload, and looks up the symbol
// at a given position of the frame.
// ----------------------------------------------------------------------------
module ppmfwg_frame (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ppmfwg_pkg::frame_ctrl_type             ctrl,
   input  logic [ppmfwg_pkg::PAYLOAD_W-1:0]       load_payload,
   input  logic [ppmfwg_pkg::INDEX_W-1:0]         symbol_idx,
   output ppmfwg_pkg::frame_stat_type             stat
);

   logic [ppmfwg_pkg::PAYLOAD_W-1:0] stored_ff, stored_in;
   logic [ppmfwg_pkg::SUM_W-1:0]     stored_sum_ff, stored_sum_in;
   logic                             pending_ff, pending_in;
   logic [ppmfwg_pkg::PAYLOAD_W-1:0] word_ff, word_in;
   logic [ppmfwg_pkg::SUM_W-1:0]     sum_ff, sum_in;
   logic                             is_data_ff, is_data_in;

   logic [2:0]                       pair_sum [8];
   logic [ppmfwg_pkg::SUM_W-1:0]     load_sum;
   logic [3:0]                       word_pos;
   logic [ppmfwg_pkg::SYMBOL_W-1:0]  sym;

   // The checksum of a payload is formed as it is loaded.
   always_comb begin
      for (int p = 0; p < 8; p++) begin
         pair_sum[p] = {1'b0, load_payload[4*p +: 2]} + {1'b0, load_payload[4*p+2 +: 2]};
      end
      load_sum = ppmfwg_pkg::FIXED_SUM;
      for (int p = 0; p < 8; p++) begin
         load_sum = load_sum + {5'd0, pair_sum[p]};
      end
   end

   always_comb begin
      stored_in     = stored_ff;
      stored_sum_in = stored_sum_ff;
      pending_in    = pending_ff;
      word_in       = word_ff;
      sum_in        = sum_ff;
      is_data_in    = is_data_ff;
      if (ctrl.load) begin
         stored_in     = load_payload;
         stored_sum_in = load_sum;
         pending_in    = 1'b1;
      end else if (ctrl.sample_go && ctrl.frame_end) begin
         if (pending_ff) begin
            word_in    = stored_ff;
            sum_in     = stored_sum_ff;
            is_data_in = 1'b1;
            pending_in = 1'b0;
         end else begin
            is_data_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         is_data_ff <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         is_data_ff <= is_data_in;
      end
      stored_ff     <= stored_in;
      stored_sum_ff <= stored_sum_in;
      word_ff       <= word_in;
      sum_ff        <= sum_in;
   end

   always_comb begin
      word_pos = symbol_idx[3:0] - 4'd12;
      if (!is_data_ff) begin
         sym = '0;
      end else if (symbol_idx < 5'd8) begin
         sym = ppmfwg_pkg::header_symbol(symbol_idx[2:0]);
      end else if (symbol_idx < 5'd12) begin
         sym = (symbol_idx[1:0] == 2'd1) ? 2'd1 : 2'd0;
      end else if (symbol_idx < 5'd28) begin
         sym = word_ff[{word_pos, 1'b0} +: 2];
      end else begin
         sym = sum_ff[{symbol_idx[1:0], 1'b0} +: 2];
      end
      stat.symbol     = sym;
      stat.data_frame = is_data_ff;
   end

`ifndef SYNTHESIS
   a_pending_clears_at_frame_end: assert property (@(posedge clock) disable iff (reset)
      $fell(pending_ff) |-> $past(ctrl.sample_go && ctrl.frame_end))
      else $error("Pending payload dropped outside a frame boundary.");

   a_data_needs_pending: assert property (@(posedge clock) disable iff (reset)
      $rose(is_data_ff) |-> $past(pending_ff))
      else $error("Data frame started without a pending payload.");

   a_frame_change_at_end: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.sample_go && ctrl.frame_end) |=> $stable(is_data_ff))
      else $error("Frame type changed in the middle of a frame.");
`endif

endmodule

// File: src/ppm_frame_waveform_generator_unit.sv
// A sample request beat yields its result beat in the next cycle.
// Throughput: one beat per cycle while the result register is free or being taken; a load beat returns no result.
// The result register is freed in the same cycle it is taken, so a stalled
// result holds off only the input channel.
// Reset is synchronous: an all-zero idle frame at position zero, no pending
// payload, and an offset of 2048.
// ----------------------------------------------------------------------------
// PPM frame waveform generator
// Steps through sample and symbol positions, shapes each sample and holds it
// in the result register until it is taken.
// ----------------------------------------------------------------------------
module ppm_frame_waveform_generator_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_op,
   input  logic [ppmfwg_pkg::PAYLOAD_W-1:0]     req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [ppmfwg_pkg::SAMPLE_W-1:0]      rsp_sample,
   output logic [ppmfwg_pkg::SYMBOL_W-1:0]      rsp_symbol,
   output logic                                 rsp_symbol_end,
   output logic                                 rsp_frame_end,
   output logic                                 rsp_data_frame,
   input  logic                                 csr_wr_en,
   input  logic [ppmfwg_pkg::SAMPLE_W-1:0]      csr_wr_data
);

   logic [ppmfwg_pkg::SAMPLE_W-1:0] offset_ff, offset_in;
   logic [ppmfwg_pkg::INDEX_W-1:0]  sample_idx_ff, sample_idx_in;
   logic [ppmfwg_pkg::INDEX_W-1:0]  symbol_idx_ff, symbol_idx_in;
   logic                            valid_ff, valid_in;
   logic [ppmfwg_pkg::SAMPLE_W-1:0] sample_ff, sample_in;
   logic [ppmfwg_pkg::SYMBOL_W-1:0] symbol_ff, symbol_in;
   logic                            sym_end_ff, sym_end_in;
   logic                            frm_end_ff, frm_end_in;
   logic                            data_ff, data_in;

   logic                            accept;
   logic                            sym_end;
   logic                            frm_end;
   logic [ppmfwg_pkg::SAMPLE_W-1:0] shaped;
   ppmfwg_pkg::frame_ctrl_type      ctrl;
   ppmfwg_pkg::frame_stat_type      stat;

   assign req_ready = !valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign sym_end   = (sample_idx_ff == ppmfwg_pkg::LAST_SAMPLE);
   assign frm_end   = sym_end && (symbol_idx_ff == ppmfwg_pkg::LAST_SYMBOL);

   always_comb begin
      ctrl.sample_go = accept && (req_op == ppmfwg_pkg::OP_SAMPLE);
      ctrl.load      = accept && (req_op == ppmfwg_pkg::OP_LOAD);
      ctrl.frame_end = frm_end;
   end

   ppmfwg_frame u_frame (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .load_payload (req_payload),
      .symbol_idx   (symbol_idx_ff),
      .stat         (stat)
   );

   ppmfwg_shaper u_shaper (
      .dc_offset  (offset_ff),
      .symbol     (stat.symbol),
      .sample_idx (sample_idx_ff),
      .sample     (shaped)
   );

   always_comb begin
      offset_in     = csr_wr_en ? csr_wr_data : offset_ff;
      sample_idx_in = sample_idx_ff;
      symbol_idx_in = symbol_idx_ff;
      valid_in      = valid_ff && !rsp_ready;
      sample_in     = sample_ff;
      symbol_in     = symbol_ff;
      sym_end_in    = sym_end_ff;
      frm_end_in    = frm_end_ff;
      data_in       = data_ff;
      if (ctrl.sample_go) begin
         valid_in      = 1'b1;
         sample_in     = shaped;
         symbol_in     = stat.symbol;
         sym_end_in    = sym_end;
         frm_end_in    = frm_end;
         data_in       = stat.data_frame;
         sample_idx_in = sample_idx_ff + 5'd1;
         if (sym_end) begin
            symbol_idx_in = symbol_idx_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff     <= ppmfwg_pkg::OFFSET_RESET;
         sample_idx_ff <= '0;
         symbol_idx_ff <= '0;
         valid_ff      <= 1'b0;
      end else begin
         offset_ff     <= offset_in;
         sample_idx_ff <= sample_idx_in;
         symbol_idx_ff <= symbol_idx_in;
         valid_ff      <= valid_in;
      end
      sample_ff  <= sample_in;
      symbol_ff  <= symbol_in;
      sym_end_ff <= sym_end_in;
      frm_end_ff <= frm_end_in;
      data_ff    <= data_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_sample     = sample_ff;
   assign rsp_symbol     = symbol_ff;
   assign rsp_symbol_end = sym_end_ff;
   assign rsp_frame_end  = frm_end_ff;
   assign rsp_data_frame = data_ff;

`ifndef SYNTHESIS
   a_frame_end_is_symbol_end: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && frm_end_ff) |-> sym_end_ff)
      else $error("Frame end flagged on a sample that does not end its symbol.");

   a_symbol_holds_within_slot: assert property (@(posedge clock) disable iff (reset)
      (sample_idx_ff != ppmfwg_pkg::LAST_SAMPLE) |=> $stable(symbol_idx_ff))
      else $error("Symbol position moved before the last sample of the symbol.");

   a_load_gives_no_beat: assert property (@(posedge clock) disable iff (reset)
      (ctrl.load && !valid_ff) |=> !valid_ff)
      else $error("A payload load produced a result beat.");
`endif

endmodule
